/* sv/efsa_pkg.sv */
// Shared types, codes and widths of the extent free-space allocator.
package efsa_pkg;

	localparam int MAX_EXTENTS_DEF     = 1024;
	localparam int FREE_BITS_TOTAL_DEF = 4096;

	localparam int OP_W  = 2;
	localparam int ID_W  = 10;
	localparam int CNT_W = 13;
	localparam int ST_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC     = 2'd0,
		OP_LOCK_MOST = 2'd1,
		OP_LOCK_ID   = 2'd2,
		OP_UNLOCK    = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_BUSY      = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		op_t              operation;
		logic [ID_W-1:0]  extent_id;
		logic [CNT_W-1:0] new_free_bits;
		logic             store_cnt;
	} req_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] result_id;
	} rsp_t;

	// One table entry as stored in the RAM.
	typedef struct packed {
		logic [CNT_W-1:0] free_count;
		logic             locked;
		logic             listed;
	} ent_t;

endpackage

/* sv/efsa_if.sv */
// Request and response channel interfaces of the extent allocator.
interface efsa_req_if;
	import efsa_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface efsa_rsp_if;
	import efsa_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/efsa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module efsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/extent_free_space_allocator_top.sv */
// Top level of the extent free-space allocator: sequencer around one table RAM.
//
// Requests arrive on req (valid/ready), one result per request leaves on rsp.
// cfg_we/cfg_wdata write the listing threshold; write it only while idle.
// Operations: allocate, lock the listed extent with the most free bits
// (lowest number on ties), lock by number, unlock with optional new count.
// Each table entry (free count, lock mark, listed mark) lives in one RAM
// with a registered read; lock by number and unlock read, modify and write
// back their entry, allocate only writes, lock most free scans first.
// After acceptance, allocate, lock most free on an empty table, or a
// request rejected on its number go straight to the result state; lock by
// number and unlock pass the modify state; lock most free scans the allocated
// entries (up to MAX_EXTENTS), one entry per cycle on the RAM port, then picks.
// One request is in work at a time; the next is taken once the current
// result sits in the output register, so a stalled receiver holds the block
// only when a second result is ready behind the first.
// Reset clears the allocation count, the threshold and the control state.
// Entries at or beyond the allocation count are never read, so the RAM
// needs no clearing pass after reset.
module extent_free_space_allocator_top #(
	parameter int MAX_EXTENTS     = efsa_pkg::MAX_EXTENTS_DEF,
	parameter int FREE_BITS_TOTAL = efsa_pkg::FREE_BITS_TOTAL_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	efsa_req_if.sink                   req,
	efsa_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [efsa_pkg::CNT_W-1:0] cfg_wdata
);
	import efsa_pkg::*;

	localparam int IDX_W = $clog2(MAX_EXTENTS);
	localparam int NUM_W = $clog2(MAX_EXTENTS + 1);
	localparam int CMP_W = (NUM_W > ID_W) ? NUM_W : ID_W;
	localparam int ENT_W = $bits(ent_t);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FREE_BITS_TOTAL);
	localparam logic [NUM_W-1:0] MAX_NUM  = NUM_W'(MAX_EXTENTS);

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_MOD       = 6'b000010,
		S_SCAN      = 6'b000100,
		S_SCAN_LAST = 6'b001000,
		S_PICK      = 6'b010000,
		S_RESP      = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] thr_q;
	logic [NUM_W-1:0] next_q;
	req_t             req_q;
	status_t          res_st_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [IDX_W-1:0] scan_addr_q;
	logic             iss_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [CNT_W-1:0] best_cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_data_q;

	logic             req_acc;
	logic             full;
	logic             id_ok;
	logic [IDX_W-1:0] id_idx;
	logic             scan_end;
	logic             cand;
	logic             slot_free;
	logic [CNT_W-1:0] mod_cnt;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	ent_t             ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	ent_t             ram_rdata;
	logic [ENT_W-1:0] ram_rbits;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign full      = (next_q == MAX_NUM);
	assign id_ok     = CMP_W'(req.data.extent_id) < CMP_W'(next_q);
	assign id_idx    = IDX_W'(CMP_W'(req.data.extent_id));
	assign scan_end  = (NUM_W'(scan_addr_q) == next_q - NUM_W'(1));
	assign ram_rdata = ent_t'(ram_rbits);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign mod_cnt   = req_q.store_cnt ? req_q.new_free_bits : ram_rdata.free_count;

	// Scan candidate: strict compare keeps the lowest number on ties.
	assign cand = iss_s1 && ram_rdata.listed && !ram_rdata.locked &&
		(!found_q || (ram_rdata.free_count > best_cnt_q));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = next_q[IDX_W-1:0];
		ram_wdata = '{free_count: FULL_CNT, locked: 1'b1, listed: 1'b0};
		ram_re    = 1'b0;
		ram_raddr = id_idx;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (req.data.operation == OP_ALLOC) begin
						ram_we = !full;
					end else if (req.data.operation != OP_LOCK_MOST) begin
						ram_re = id_ok;
					end
				end
			end
			S_MOD: begin
				ram_waddr = IDX_W'(CMP_W'(req_q.extent_id));
				if (req_q.operation == OP_UNLOCK) begin
					ram_we    = ram_rdata.locked;
					ram_wdata = '{free_count: mod_cnt, locked: 1'b0,
						listed: (mod_cnt > thr_q)};
				end else begin
					ram_we    = !ram_rdata.locked;
					ram_wdata = '{free_count: ram_rdata.free_count, locked: 1'b1,
						listed: 1'b0};
				end
			end
			S_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = scan_addr_q;
			end
			S_PICK: begin
				ram_we    = found_q;
				ram_waddr = best_idx_q;
				ram_wdata = '{free_count: best_cnt_q, locked: 1'b1, listed: 1'b0};
			end
			S_SCAN_LAST, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	efsa_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_EXTENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rbits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			next_q  <= '0;
			iss_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			iss_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						case (req.data.operation)
							OP_ALLOC: begin
								if (!full) begin
									next_q <= next_q + NUM_W'(1);
								end
								state_q <= S_RESP;
							end
							OP_LOCK_MOST: begin
								found_q <= 1'b0;
								state_q <= (next_q == '0) ? S_RESP : S_SCAN;
							end
							default: begin
								state_q <= id_ok ? S_MOD : S_RESP;
							end
						endcase
					end
				end
				S_MOD: begin
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (cand) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_SCAN_LAST;
					end
				end
				S_SCAN_LAST: begin
					if (cand) begin
						found_q <= 1'b1;
					end
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: request, scan pointer, best entry and pending result.
	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr_q;
		if (req_acc) begin
			req_q       <= req.data;
			scan_addr_q <= '0;
			case (req.data.operation)
				OP_ALLOC: begin
					res_st_q  <= full ? ST_FULL : ST_OK;
					res_idx_q <= next_q[IDX_W-1:0];
				end
				OP_LOCK_MOST: begin
					res_st_q  <= ST_BUSY;
					res_idx_q <= '0;
				end
				default: begin
					res_st_q <= id_ok ? ST_OK : ST_NOT_ALLOC;
					res_idx_q <= id_idx;
				end
			endcase
		end
		if (state_q == S_SCAN) begin
			scan_addr_q <= scan_addr_q + IDX_W'(1);
		end
		if (cand) begin
			best_idx_q <= idx_s1;
			best_cnt_q <= ram_rdata.free_count;
		end
		if (state_q == S_MOD) begin
			if (req_q.operation == OP_UNLOCK) begin
				res_st_q <= ram_rdata.locked ? ST_OK : ST_BUSY;
			end else begin
				res_st_q <= ram_rdata.locked ? ST_BUSY : ST_OK;
			end
		end
		if (state_q == S_PICK) begin
			res_st_q  <= found_q ? ST_OK : ST_BUSY;
			res_idx_q <= best_idx_q;
		end
	end

	// Output register: load the pending result once the slot frees up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESP && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && slot_free) begin
			rsp_data_q.status    <= res_st_q;
			rsp_data_q.result_id <= (res_st_q == ST_OK) ? ID_W'(res_idx_q) : '0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && (ram_waddr == ram_raddr)))
		else $error("table read and write collide on one entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= MAX_NUM)
		else $error("allocation count beyond table depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (NUM_W'(scan_addr_q) < next_q))
		else $error("scan reads an unallocated entry");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.data.operation == OP_ALLOC && !full)
		|=> (next_q == $past(next_q) + NUM_W'(1)))
		else $error("allocate did not advance the count");

	a_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && found_q) |-> (NUM_W'(best_idx_q) < next_q))
		else $error("picked entry outside allocated range");

endmodule

/* bench/tb_top.sv */
// Testbench for the extent free-space allocator: directed and random requests checked on a table model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import efsa_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int CNT_TOP = FREE_BITS_TOTAL_DEF;
	localparam int ID_TOP = MAX_EXTENTS_DEF - 1;
	localparam int LONG_HOLD = 500;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FREE_BITS_TOTAL_DEF);

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	efsa_req_if req_ch();
	efsa_rsp_if rsp_ch();

	extent_free_space_allocator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5ns clk = ~clk;

	// table model
	logic [CNT_W-1:0] free_cnt [MAX_EXTENTS_DEF];
	bit held_mark [MAX_EXTENTS_DEF];
	bit list_mark [MAX_EXTENTS_DEF];
	int alloc_cnt = 0;
	logic [CNT_W-1:0] list_limit = '0;

	req_t req_backlog[$];
	rsp_t predicted_rsp[$];

	int send_gap;
	int recv_stall;
	int long_hold_left;
	bit hold_done;
	bit idle_on = 1'b1;
	int reqs_taken = 0;
	int rsps_seen = 0;
	int mismatches = 0;
	int cycles = 0;
	int gen_allocs = 0;
	int status_seen [4] = '{default: 0};

	// Apply one request to the table model and return the response it must produce.
	function automatic rsp_t apply_to_table(req_t r);
		rsp_t o;
		bit found;
		int best;
		int idx;
		o.status = ST_OK;
		o.result_id = '0;
		found = 1'b0;
		best = 0;
		idx = int'(r.extent_id);
		case (r.operation)
			OP_ALLOC: begin
				if (alloc_cnt >= MAX_EXTENTS_DEF) begin
					o.status = ST_FULL;
				end else begin
					o.result_id = ID_W'(alloc_cnt);
					free_cnt[alloc_cnt] = FULL_CNT;
					held_mark[alloc_cnt] = 1'b1;
					list_mark[alloc_cnt] = 1'b0;
					alloc_cnt++;
				end
			end
			OP_LOCK_MOST: begin
				// strict compare keeps the lowest number on ties
				for (int i = 0; i < alloc_cnt; i++) begin
					if (list_mark[i] && !held_mark[i] &&
							(!found || free_cnt[i] > free_cnt[best])) begin
						best = i;
						found = 1'b1;
					end
				end
				if (!found) begin
					o.status = ST_BUSY;
				end else begin
					list_mark[best] = 1'b0;
					held_mark[best] = 1'b1;
					o.result_id = ID_W'(best);
				end
			end
			default: begin
				if (idx >= alloc_cnt) begin
					o.status = ST_NOT_ALLOC;
				end else if (r.operation == OP_LOCK_ID) begin
					if (held_mark[idx]) begin
						o.status = ST_BUSY;
					end else begin
						held_mark[idx] = 1'b1;
						list_mark[idx] = 1'b0;
						o.result_id = r.extent_id;
					end
				end else if (!held_mark[idx]) begin
					o.status = ST_BUSY;
				end else begin
					if (r.store_cnt)
						free_cnt[idx] = r.new_free_bits;
					list_mark[idx] = free_cnt[idx] > list_limit;
					held_mark[idx] = 1'b0;
					o.result_id = r.extent_id;
				end
			end
		endcase
		return o;
	endfunction

	task automatic queue_req(op_t op, int id, int nfb, bit upd);
		req_t r;
		r.operation = op;
		r.extent_id = ID_W'(id);
		r.new_free_bits = CNT_W'(nfb);
		r.store_cnt = upd;
		req_backlog = {req_backlog, r};
		if (op == OP_ALLOC)
			gen_allocs++;
	endtask

	function automatic int rand_count();
		int t;
		case ($urandom_range(0, 7))
			0: return 0;
			1: return CNT_TOP;
			2: begin
				// land on or next to the threshold
				t = int'(list_limit) + int'($urandom_range(0, 2)) - 1;
				if (t < 0)
					t = 0;
				if (t > CNT_TOP)
					t = CNT_TOP;
				return t;
			end
			default: return int'($urandom_range(0, CNT_TOP));
		endcase
	endfunction

	function automatic int rand_id();
		if ($urandom_range(0, 9) == 0)
			return int'($urandom_range(0, ID_TOP));
		return int'($urandom_range(0, gen_allocs < ID_TOP ? gen_allocs : ID_TOP));
	endfunction

	// Wait until every request is sent and every response has come back.
	task automatic drain();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || req_ch.valid || predicted_rsp.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_threshold(logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		list_limit = v;
		@(negedge clk);
	endtask

	task automatic random_phase(int n, logic [CNT_W-1:0] thr, bit idles);
		int k;
		int id;
		int pick;
		drain();
		idle_on = idles;
		set_threshold(thr);
		k = 0;
		while (k < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 25 && gen_allocs > 0) begin
				// lock then unlock the same extent
				id = $urandom_range(0, gen_allocs - 1 < ID_TOP ? gen_allocs - 1 : ID_TOP);
				queue_req(OP_LOCK_ID, id, rand_count(), 1'($urandom_range(0, 1)));
				queue_req(OP_UNLOCK, id, rand_count(), 1'($urandom_range(0, 1)));
				k += 2;
			end else begin
				if (pick < 33)
					queue_req(OP_ALLOC, rand_id(), rand_count(), 1'($urandom_range(0, 1)));
				else if (pick < 55)
					queue_req(OP_LOCK_MOST, rand_id(), rand_count(), 1'($urandom_range(0, 1)));
				else if (pick < 75)
					queue_req(OP_LOCK_ID, rand_id(), rand_count(), 1'($urandom_range(0, 1)));
				else
					queue_req(OP_UNLOCK, rand_id(), rand_count(), 1'($urandom_range(0, 1)));
				k++;
			end
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			send_gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predicted_rsp = {predicted_rsp, apply_to_table(req_ch.data)};
				reqs_taken <= reqs_taken + 1;
			end
			if (req_ch.valid && !req_ch.ready) begin
				// hold the offered request
			end else if (send_gap != 0) begin
				req_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				req_ch.valid <= 1'b0;
				send_gap <= $urandom_range(0, 17);
			end else if (req_backlog.size() != 0) begin
				req_ch.valid <= 1'b1;
				req_ch.data <= req_backlog.pop_front();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// one long receiver hold-off so the block fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && reqs_taken >= 150) begin
			long_hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (long_hold_left != 0) begin
			long_hold_left <= long_hold_left - 1;
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsps_seen++;
				if (!$isunknown(rsp_ch.data.status))
					status_seen[rsp_ch.data.status]++;
				if (predicted_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response with none pending: status %0d id %0d",
							$realtime, rsp_ch.data.status, rsp_ch.data.result_id);
				end else begin
					want = predicted_rsp.pop_front();
					if (want.status !== rsp_ch.data.status ||
							want.result_id !== rsp_ch.data.result_id) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: response %0d: status exp %0d got %0d, id exp %0d got %0d",
								$realtime, rsps_seen, want.status, rsp_ch.data.status,
								want.result_id, rsp_ch.data.result_id);
					end
				end
			end
			if (long_hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
			end else if (recv_stall != 0) begin
				rsp_ch.ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				recv_stall <= $urandom_range(0, 17);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses pending", cycles,
				predicted_rsp.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_threshold('0);

		// empty table, rejects on unallocated numbers
		queue_req(OP_LOCK_MOST, 0, 0, 1'b0);
		queue_req(OP_LOCK_ID, 0, 0, 1'b0);
		queue_req(OP_UNLOCK, ID_TOP, CNT_TOP, 1'b1);
		queue_req(OP_ALLOC, 0, 0, 1'b0);
		queue_req(OP_ALLOC, ID_TOP, CNT_TOP, 1'b1);
		queue_req(OP_ALLOC, 0, 0, 1'b0);
		// already locked, then unlock twice
		queue_req(OP_LOCK_ID, 1, 0, 1'b0);
		queue_req(OP_UNLOCK, 1, 100, 1'b1);
		queue_req(OP_UNLOCK, 1, 0, 1'b0);
		queue_req(OP_UNLOCK, 2, 100, 1'b1);
		queue_req(OP_UNLOCK, 0, 0, 1'b0);
		// most free first, then the tie goes to the lower number
		queue_req(OP_LOCK_MOST, 0, 0, 1'b0);
		queue_req(OP_LOCK_MOST, 0, 0, 1'b0);
		queue_req(OP_LOCK_ID, 2, 0, 1'b0);
		// zero count is not above a zero threshold
		queue_req(OP_UNLOCK, 2, 0, 1'b1);
		queue_req(OP_LOCK_MOST, 0, 0, 1'b0);
		queue_req(OP_LOCK_ID, 2, 0, 1'b0);
		queue_req(OP_UNLOCK, 2, CNT_TOP - 1, 1'b1);
		queue_req(OP_UNLOCK, 0, CNT_TOP, 1'b1);
		queue_req(OP_LOCK_ID, ID_TOP, 0, 1'b1);
		queue_req(OP_ALLOC, 512, 4095, 1'b1);
		queue_req(OP_LOCK_MOST, 0, 0, 1'b0);

		random_phase(110, FULL_CNT, 1'b1);
		random_phase(110, '0, 1'b1);
		random_phase(110, 13'd2048, 1'b0);
		random_phase(110, CNT_W'($urandom_range(1, CNT_TOP - 1)), 1'b1);
		random_phase(110, 13'd1, 1'b0);

		// close with the highest numbers and a few scans, no idling
		drain();
		idle_on = 1'b0;
		set_threshold(13'd4095);
		queue_req(OP_LOCK_MOST, 0, 0, 1'b0);
		queue_req(OP_UNLOCK, ID_TOP, CNT_TOP, 1'b1);
		queue_req(OP_UNLOCK, ID_TOP - 1, 4095, 1'b1);
		queue_req(OP_LOCK_MOST, 0, 0, 1'b0);
		queue_req(OP_LOCK_ID, ID_TOP, 0, 1'b0);
		queue_req(OP_UNLOCK, ID_TOP, 0, 1'b0);
		queue_req(OP_LOCK_MOST, ID_TOP, CNT_TOP, 1'b1);
		queue_req(OP_ALLOC, ID_TOP, CNT_TOP, 1'b1);
		queue_req(OP_LOCK_ID, ID_TOP, 0, 1'b0);
		drain();

		$display("Checked %0d responses to %0d requests: %0d ok, %0d busy, %0d unallocated, %0d full",
			rsps_seen, reqs_taken, status_seen[ST_OK], status_seen[ST_BUSY],
			status_seen[ST_NOT_ALLOC], status_seen[ST_FULL]);
		$display("Table grown to %0d extents over six threshold settings, one %0d-cycle receiver hold",
			alloc_cnt, LONG_HOLD);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
